>>> rtl/ssns_pkg.sv
// shared constants and types for the seven segment number scan block
package ssns_pkg;

    localparam int MAX_DISPLAYS = 8;
    localparam int NUMBER_W     = 32;
    localparam int FRAC_BITS    = 8;
    localparam int BCD_DIGITS   = 17;
    localparam int BCD_W        = 4 * BCD_DIGITS;
    localparam int POS_W        = 3;
    localparam int SYM_W        = 4;
    localparam int DP_W         = 3;
    localparam int COUNT_W      = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int STEP_W       = 5;

    localparam logic [SYM_W-1:0]     SYM_MINUS = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMAL_PLACES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_PAD       = 2'd2;

    localparam logic [COUNT_W-1:0]   DISPLAY_COUNT_RESET = 4'd2;

    typedef struct packed {
        logic start;
        logic shift;
    } conv_ctrl_t;

endpackage

>>> rtl/seven_segment_number_scan_top.sv
// top level: config registers, scan sequencer and registered slot output
// a value is converted in turn by the bit-serial binary to bcd build, the decimal_places
// scaling and the halving, then one slot a cycle is given while out_stall is low
// a new value is held off by in_stall while the bit-serial decimal conversion and the
// slots of the last value run; a new value is taken while the last slot waits
// a display count of zero takes the value and gives no slots
// reset: asynchronous, active low; display_count 2, decimal_places 0, zero_pad 0
module seven_segment_number_scan_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ssns_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ssns_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ssns_pkg::NUMBER_W-1:0]  number,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ssns_pkg::POS_W-1:0]            position,
    output logic [ssns_pkg::SYM_W-1:0]            symbol,
    output logic                                  point,
    output logic                                  final_slot
);
    import ssns_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } scan_state_t;

    scan_state_t          state_reg;
    logic [COUNT_W-1:0]   display_count_reg;
    logic [DP_W-1:0]      decimal_places_reg;
    logic                 zero_pad_reg;
    logic                 neg_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 out_valid_reg;
    logic [POS_W-1:0]     position_reg;
    logic [SYM_W-1:0]     symbol_reg;
    logic                 point_reg;
    logic                 final_reg;

    conv_ctrl_t           ctrl;
    logic                 conv_done;
    logic [BCD_W-1:0]     bcd;
    logic [NUMBER_W-1:0]  mag;
    logic                 in_take;
    logic                 can_load;
    logic [COUNT_W-1:0]   count;
    logic [COUNT_W-1:0]   pos_inc;
    logic                 last;
    logic                 beyond;
    logic                 after_zero;
    logic                 next_break;
    logic [SYM_W-1:0]     sym_next;
    logic                 point_next;
    logic                 final_next;
    logic                 shift_next;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign mag       = number[NUMBER_W-1] ? (NUMBER_W'(0) - NUMBER_W'(number))
                                          : NUMBER_W'(number);
    assign count     = (display_count_reg > COUNT_W'(MAX_DISPLAYS))
                     ? COUNT_W'(MAX_DISPLAYS) : display_count_reg;
    assign can_load  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    // slot selection
    always_comb
    begin
        pos_inc    = {1'b0, pos_reg} + 1'b1;
        last       = (pos_inc == count);
        beyond     = (bcd == '0) && (pos_reg > decimal_places_reg);
        sym_next   = bcd[SYM_W-1:0];
        point_next = 1'b0;
        shift_next = 1'b0;
        if (beyond)
        begin
            if (neg_reg && (!zero_pad_reg || last))
            begin
                sym_next = SYM_MINUS;
            end
            else
            begin
                sym_next = '0;
            end
        end
        else
        begin
            shift_next = 1'b1;
            point_next = (decimal_places_reg != '0) && (pos_reg == decimal_places_reg);
        end
        after_zero = shift_next ? (bcd[BCD_W-1:4] == '0) : 1'b1;
        next_break = !zero_pad_reg && !neg_reg && after_zero
                  && (pos_inc > {1'b0, decimal_places_reg});
        final_next = last || ((sym_next == SYM_MINUS) && !zero_pad_reg) || next_break;
    end

    assign ctrl = '{start: in_take && (count != '0), shift: can_load && shift_next};

    ssns_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .mag      (mag),
        .decimals (decimal_places_reg),
        .done     (conv_done),
        .bcd      (bcd)
    );

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_count_reg  <= DISPLAY_COUNT_RESET;
            decimal_places_reg <= '0;
            zero_pad_reg       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DISPLAY_COUNT:  display_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_DECIMAL_PLACES: decimal_places_reg <= cfg_data[DP_W-1:0];
                CFG_ZERO_PAD:       zero_pad_reg       <= cfg_data[0];
                default:            zero_pad_reg       <= zero_pad_reg;
            endcase
        end
    end

    // scan sequencer and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            pos_reg       <= '0;
            position_reg  <= '0;
            symbol_reg    <= '0;
            point_reg     <= 1'b0;
            final_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !can_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        state_reg <= S_CONV;
                        neg_reg   <= number[NUMBER_W-1];
                    end
                end
                S_CONV:
                begin
                    if (conv_done)
                    begin
                        state_reg <= S_EMIT;
                        pos_reg   <= '0;
                    end
                end
                S_EMIT:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        position_reg  <= pos_reg;
                        symbol_reg    <= sym_next;
                        point_reg     <= point_next;
                        final_reg     <= final_next;
                        pos_reg       <= pos_reg + 1'b1;
                        if (final_next)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign position   = position_reg;
    assign symbol     = symbol_reg;
    assign point      = point_reg;
    assign final_slot = final_reg;

endmodule

>>> rtl/ssns_conv.sv
// magnitude to scaled decimal digits: bit-serial bcd build, digit shifts, bcd halving
module ssns_conv (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ssns_pkg::conv_ctrl_t              ctrl,
    input  logic [ssns_pkg::NUMBER_W-1:0]     mag,
    input  logic [ssns_pkg::DP_W-1:0]         decimals,
    output logic                              done,
    output logic [ssns_pkg::BCD_W-1:0]        bcd
);
    import ssns_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE,
        C_BIN,
        C_SCALE,
        C_HALVE
    } conv_state_t;

    conv_state_t             state_reg;
    logic [STEP_W-1:0]       step_reg;
    logic                    done_reg;
    logic [NUMBER_W-1:0]     bin_reg;
    logic [BCD_W-1:0]        bcd_reg;
    logic [BCD_W-1:0]        adj_next;
    logic [BCD_W-1:0]        half_next;

    // add three to every digit of five or more before the doubling shift
    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
            begin
                adj_next[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end
            else
            begin
                adj_next[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    // divide by two: each digit halves and takes five from an odd digit above
    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (k < BCD_DIGITS - 1)
            begin
                half_next[4*k +: 4] = {1'b0, bcd_reg[4*k+1 +: 3]}
                                    + (bcd_reg[4*(k+1)] ? 4'd5 : 4'd0);
            end
            else
            begin
                half_next[4*k +: 4] = {1'b0, bcd_reg[4*k+1 +: 3]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        state_reg <= C_BIN;
                        step_reg  <= STEP_W'(NUMBER_W - 1);
                    end
                end
                C_BIN:
                begin
                    if (step_reg == '0)
                    begin
                        if (decimals != '0)
                        begin
                            state_reg <= C_SCALE;
                            step_reg  <= STEP_W'(decimals);
                        end
                        else
                        begin
                            state_reg <= C_HALVE;
                            step_reg  <= STEP_W'(FRAC_BITS - 1);
                        end
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                C_SCALE:
                begin
                    if (step_reg == STEP_W'(1))
                    begin
                        state_reg <= C_HALVE;
                        step_reg  <= STEP_W'(FRAC_BITS - 1);
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                C_HALVE:
                begin
                    if (step_reg == '0)
                    begin
                        state_reg <= C_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    // digit datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (ctrl.start)
                begin
                    bin_reg <= mag;
                    bcd_reg <= '0;
                end
                else if (ctrl.shift)
                begin
                    bcd_reg <= {4'd0, bcd_reg[BCD_W-1:4]};
                end
            end
            C_BIN:
            begin
                bcd_reg <= {adj_next[BCD_W-2:0], bin_reg[NUMBER_W-1]};
                bin_reg <= {bin_reg[NUMBER_W-2:0], 1'b0};
            end
            C_SCALE:
            begin
                bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};
            end
            C_HALVE:
            begin
                bcd_reg <= half_next;
            end
            default:
            begin
                bcd_reg <= bcd_reg;
            end
        endcase
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

>>> rtl/ssns_check.sv
// port-level checks for the scan top level, bound to it
module ssns_check (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [ssns_pkg::POS_W-1:0]            position,
    input logic [ssns_pkg::SYM_W-1:0]            symbol,
    input logic                                  point,
    input logic                                  final_slot
);
    import ssns_pkg::*;

    // a held word keeps its symbol, position and final flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(position)
                                  && $stable(final_slot))
        else $error("held output word changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> symbol <= SYM_MINUS)
        else $error("symbol code out of range");

    // the point only comes with a digit, never on the lowest position
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point |-> symbol != SYM_MINUS && position != '0)
        else $error("point on minus sign or position zero");

    // a slot after a non-final slot is the next position up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !final_slot ##1 out_valid
            |-> position == $past(position) + 1'b1)
        else $error("scan position skipped");

endmodule

bind seven_segment_number_scan_top ssns_check u_ssns_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .position   (position),
    .symbol     (symbol),
    .point      (point),
    .final_slot (final_slot)
);

>>> verif/tb.sv
// testbench for the seven segment number scan block: directed and random values checked slot by slot
module tb;
    import ssns_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          SETTLE_CYCLES = 80;
    localparam int          PHASE_ITEMS   = 40;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [SYM_W-1:0] symbol;
        logic             point;
        logic             final_slot;
    } slot_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [NUMBER_W-1:0] number;
    logic                  out_valid;
    logic                  out_stall;
    logic [POS_W-1:0]      position;
    logic [SYM_W-1:0]      symbol;
    logic                  point;
    logic                  final_slot;

    logic [COUNT_W-1:0]    digits_in_use;
    logic [DP_W-1:0]       decimals;
    logic                  pad_zeros;

    slot_t       pending_slots[$];
    int          mismatches;
    int unsigned cycles;
    bit          quiet;

    seven_segment_number_scan_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .number     (number),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .symbol     (symbol),
        .point      (point),
        .final_slot (final_slot)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // expected scan slots for one value under the current register settings
    function automatic void predict_scan_slots(logic [NUMBER_W-1:0] value);
        slot_t       slots[MAX_DISPLAYS];
        bit          neg;
        bit [31:0]   mag;
        bit [63:0]   scale;
        bit [63:0]   scaled;
        int          count;
        int          n;
        int          i;
        logic [SYM_W-1:0] sym;
        logic        pt;
        neg = value[NUMBER_W-1];
        mag = neg ? 32'(-value) : 32'(value);
        scale = 1;
        repeat (decimals) scale = scale * 10;
        scaled = (64'(mag) * scale) >> FRAC_BITS;
        count = (digits_in_use > MAX_DISPLAYS) ? MAX_DISPLAYS : int'(digits_in_use);
        n = 0;
        for (i = 0; i < count; i++)
        begin
            pt = 1'b0;
            if (scaled == 0 && i > decimals)
            begin
                if (neg && !pad_zeros)
                begin
                    sym = SYM_MINUS;
                    neg = 1'b0;
                end
                else if (neg && pad_zeros && i == count - 1)
                    sym = SYM_MINUS;
                else if (pad_zeros)
                    sym = '0;
                else
                    break;
            end
            else
            begin
                sym = SYM_W'(scaled % 10);
                scaled = scaled / 10;
                pt = (decimals != 0 && i == decimals);
            end
            slots[n] = '{position: POS_W'(i), symbol: sym, point: pt, final_slot: 1'b0};
            n++;
            if (sym == SYM_MINUS && !pad_zeros)
                break;
        end
        for (i = 0; i < n; i++)
        begin
            slots[i].final_slot = (i == n - 1);
            pending_slots.push_back(slots[i]);
        end
    endfunction

    task automatic send_number(logic [NUMBER_W-1:0] value);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        number = value;
        do
            @(posedge clk);
        while (in_stall);
        predict_scan_slots(value);
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_slots.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DISPLAY_COUNT:  digits_in_use = data[COUNT_W-1:0];
            CFG_DECIMAL_PLACES: decimals = data[DP_W-1:0];
            CFG_ZERO_PAD:       pad_zeros = data[0];
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(int count, int dp, int pad);
        settle();
        write_reg(CFG_DISPLAY_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_DECIMAL_PLACES, CFG_DATA_W'(dp));
        write_reg(CFG_ZERO_PAD, CFG_DATA_W'(pad));
    endtask

    function automatic logic [NUMBER_W-1:0] random_number();
        int          r;
        logic [31:0] m;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        if (r < 9)
        begin
            m = (r < 7) ? $urandom_range(0, 1 << 16) : $urandom_range(0, 255);
            return $urandom_range(0, 1) ? -m : m;
        end
        case ($urandom_range(0, 3))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'hffffffff;
            default: return 32'h0;
        endcase
    endfunction

    task automatic test_reset_settings();
        send_number(32'd0);
        send_number(32'd256);
        send_number(-32'sd256);
        send_number(32'hffffffff);
        send_number(32'd2560);
    endtask

    task automatic test_wide_display();
        set_config(8, 7, 0);
        send_number(32'h7fffffff);
        send_number(32'h80000000);
        send_number(32'd1);
        send_number(32'hffffffff);
    endtask

    task automatic test_zero_padding();
        set_config(4, 0, 1);
        send_number(-32'sd256 * 12345);
        send_number(-32'sd256 * 12);
        send_number(32'd256 * 7);
        send_number(32'd0);
    endtask

    task automatic test_register_masking();
        settle();
        write_reg(CFG_DISPLAY_COUNT, 4'd15);
        write_reg(CFG_DECIMAL_PLACES, 4'hf);
        write_reg(CFG_ZERO_PAD, 4'he);
        write_reg(CFG_UNUSED, 4'h5);
        send_number(32'h80000000);
        send_number(-32'sd128);
        set_config(0, 3, 1);
        send_number(32'd12345);
        send_number(32'hffffffff);
    endtask

    task automatic test_decimal_point();
        set_config(6, 2, 0);
        send_number(32'd256 * 3 + 128);
        send_number(-32'sd64);
        send_number(32'hffffffff);
    endtask

    task automatic test_random_sweep();
        int p;
        int count;
        int dp;
        for (p = 0; p < 10; p++)
        begin
            count = (p == 0) ? 1 : (p == 1) ? 8 : $urandom_range(1, 8);
            dp    = (p == 0) ? 0 : (p == 1) ? 7 : $urandom_range(0, 7);
            set_config(count, dp, p % 2);
            quiet = (p == 3);
            repeat (PHASE_ITEMS) send_number(random_number());
            quiet = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : check_slots
        slot_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_slots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected slot: pos %0d sym %0d point %0b final %0b",
                             position, symbol, point, final_slot);
            end
            else
            begin
                want = pending_slots.pop_front();
                if (position !== want.position || symbol !== want.symbol ||
                    point !== want.point || final_slot !== want.final_slot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("slot mismatch: expected pos %0d sym %0d point %0b final %0b, got pos %0d sym %0d point %0b final %0b",
                                 want.position, want.symbol, want.point, want.final_slot,
                                 position, symbol, point, final_slot);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : drive_out_stall
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = pick_gap();
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        number = '0;
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        digits_in_use = DISPLAY_COUNT_RESET;
        decimals = '0;
        pad_zeros = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_settings();
        test_wide_display();
        test_zero_padding();
        test_register_masking();
        test_decimal_point();
        test_random_sweep();
        settle();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
